[design/echo_distance_median_filter_macros.svh]
// assertion macros for the echo distance median filter
`ifndef ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH
`define ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define EDMF_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");
// next-cycle implication, disabled while in reset
`define EDMF_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");
`else
`define EDMF_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define EDMF_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[design/edmf_pkg.sv]
// shared types and constants of the echo distance median filter
`timescale 1ns / 1ps
`default_nettype none
package edmf_pkg;

    localparam int DIST_W = 16;
    localparam int DIV_W  = 8;

    localparam logic [DIV_W-1:0] US_PER_CM_RESET = 8'd58;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } status_t;

    // request to the rank selection unit
    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] sample;
    } rank_req_t;

endpackage
`default_nettype wire

[design/edmf_divider.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module edmf_divider
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [edmf_pkg::DIST_W-1:0] dividend,
    input  wire logic [edmf_pkg::DIV_W-1:0]  divisor,
    output edmf_pkg::status_t                status,
    output logic      [edmf_pkg::DIST_W-1:0] quotient
);

    localparam int CNT_W = $clog2(edmf_pkg::DIST_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [edmf_pkg::DIST_W-1:0] dvd_reg;
    logic [edmf_pkg::DIV_W-1:0]  rem_reg;
    logic [edmf_pkg::DIV_W-1:0]  div_reg;

    logic [edmf_pkg::DIV_W:0]    trial;
    logic [edmf_pkg::DIV_W:0]    diff;
    logic                        q_bit;
    logic [edmf_pkg::DIV_W-1:0]  rem_next;

    // a zero divisor always subtracts, so the quotient saturates to all ones
    assign trial    = {rem_reg, dvd_reg[edmf_pkg::DIST_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign q_bit    = (trial >= {1'b0, div_reg});
    assign rem_next = q_bit ? diff[edmf_pkg::DIV_W-1:0] : trial[edmf_pkg::DIV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(edmf_pkg::DIST_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[edmf_pkg::DIST_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule
`default_nettype wire

[design/edmf_rank_select.sv]
// sample window as a rotating ring with one shared comparator for rank counting
`timescale 1ns / 1ps
`default_nettype none
module edmf_rank_select
#(
    parameter int WINDOW = 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  edmf_pkg::rank_req_t              req,
    output edmf_pkg::status_t                status,
    output logic      [edmf_pkg::DIST_W-1:0] median
);

    localparam int CW   = $clog2(WINDOW + 1);
    localparam int IW   = $clog2(WINDOW);
    localparam int RANK = WINDOW / 2;

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_LOAD = 2'd1;
    localparam logic [1:0] R_CMP  = 2'd2;
    localparam logic [1:0] R_SKIP = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [edmf_pkg::DIST_W-1:0] win_reg [WINDOW];
    logic [edmf_pkg::DIST_W-1:0] cand_reg;
    logic [CW-1:0]               below_reg;
    logic [CW-1:0]               not_above_reg;
    logic [IW-1:0]               step_reg;
    logic [IW-1:0]               cand_cnt_reg;
    logic [edmf_pkg::DIST_W-1:0] median_reg;
    logic                        done_reg;
    logic                        rotate;
    logic                        last_cand;
    logic                        rank_hit;

    // oldest entry drops out at the far end, so a shift equals the ring write
    assign rotate    = (state_reg == R_LOAD) || (state_reg == R_CMP) || (state_reg == R_SKIP);
    assign last_cand = (cand_cnt_reg == IW'(WINDOW - 1));
    assign rank_hit  = (below_reg <= CW'(RANK)) && (CW'(RANK) < not_above_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    state_next = R_LOAD;
                end
            end
            R_LOAD:
            begin
                state_next = R_CMP;
            end
            R_CMP:
            begin
                if (step_reg == IW'(WINDOW - 2))
                begin
                    state_next = R_SKIP;
                end
            end
            R_SKIP:
            begin
                state_next = last_cand ? R_IDLE : R_LOAD;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= R_IDLE;
            step_reg     <= '0;
            cand_cnt_reg <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == R_SKIP) && last_cand;
            if ((state_reg == R_IDLE) && req.start)
            begin
                win_reg[0] <= req.sample;
                for (int i = 1; i < WINDOW; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            else if (rotate)
            begin
                win_reg[WINDOW-1] <= win_reg[0];
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
            end
            if (state_reg == R_LOAD)
            begin
                step_reg <= '0;
            end
            else if (state_reg == R_CMP)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == R_SKIP)
            begin
                cand_cnt_reg <= last_cand ? '0 : cand_cnt_reg + 1'b1;
            end
        end
    end

    // candidate counts itself once at load; the others pass the comparator
    always_ff @(posedge clk)
    begin
        if (state_reg == R_LOAD)
        begin
            cand_reg      <= win_reg[0];
            below_reg     <= '0;
            not_above_reg <= CW'(1);
        end
        else if (state_reg == R_CMP)
        begin
            if (win_reg[0] < cand_reg)
            begin
                below_reg <= below_reg + 1'b1;
            end
            if (win_reg[0] <= cand_reg)
            begin
                not_above_reg <= not_above_reg + 1'b1;
            end
        end
        if ((state_reg == R_SKIP) && rank_hit)
        begin
            median_reg <= cand_reg;
        end
    end

    assign status.busy = (state_reg != R_IDLE);
    assign status.done = done_reg;
    assign median      = median_reg;

endmodule
`default_nettype wire

[design/echo_distance_median_filter.sv]
// echo time to distance conversion with sliding window median
// flow: each item passes the serial divider, then the single comparator rank count over the
//   rotating window, then the output register; a new item is taken only once the sequencer is
//   idle again, and a result that finds the output register still stalled holds back the next item
// reset: window cleared to zero, divisor back to 58, no result pending
`timescale 1ns / 1ps
`default_nettype none
`include "echo_distance_median_filter_macros.svh"
module echo_distance_median_filter
#(
    parameter int WINDOW = 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input item channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [edmf_pkg::DIST_W-1:0] echo_time_us,
    // result item channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [edmf_pkg::DIST_W-1:0] raw_cm,
    output logic      [edmf_pkg::DIST_W-1:0] median_cm,
    // divisor write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [edmf_pkg::DIV_W-1:0]  cfg_data
);

    // sequencer codes
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_DIV  = 2'd1;
    localparam logic [1:0] T_RANK = 2'd2;
    localparam logic [1:0] T_HOLD = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [edmf_pkg::DIV_W-1:0]  us_per_cm_reg;
    logic [edmf_pkg::DIST_W-1:0] raw_reg;
    logic                        out_valid_reg;
    logic [edmf_pkg::DIST_W-1:0] out_raw_reg;
    logic [edmf_pkg::DIST_W-1:0] out_median_reg;

    logic                        in_accept;
    logic                        slot_free;
    logic                        out_load;
    edmf_pkg::status_t           div_st;
    edmf_pkg::status_t           rank_st;
    edmf_pkg::rank_req_t         rank_req;
    logic [edmf_pkg::DIST_W-1:0] quotient;
    logic [edmf_pkg::DIST_W-1:0] median;

    // new items are taken only while both units are free; the output register
    // lets one finished result wait while the next item starts
    assign in_stall  = (state_reg != T_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // output slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = (((state_reg == T_RANK) && rank_st.done) || (state_reg == T_HOLD))
                       && slot_free;

    // distance goes into the window as soon as the divider finishes
    assign rank_req.start  = (state_reg == T_DIV) && div_st.done;
    assign rank_req.sample = quotient;

    edmf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .dividend (echo_time_us),
        .divisor  (us_per_cm_reg),
        .status   (div_st),
        .quotient (quotient)
    );

    edmf_rank_select
    #(
        .WINDOW (WINDOW)
    )
    u_rank
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (rank_req),
        .status (rank_st),
        .median (median)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = T_DIV;
                end
            end
            T_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = T_RANK;
                end
            end
            T_RANK:
            begin
                if (rank_st.done)
                begin
                    state_next = slot_free ? T_IDLE : T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            us_per_cm_reg <= edmf_pkg::US_PER_CM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                us_per_cm_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (rank_req.start)
        begin
            raw_reg <= quotient;
        end
        if (out_load)
        begin
            out_raw_reg    <= raw_reg;
            out_median_reg <= median;
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_cm    = out_raw_reg;
    assign median_cm = out_median_reg;

    // a unit finishing outside its own phase means the sequencer lost track
    `EDMF_ASSERT_IMPLY(a_div_done_phase, clk, rst_n, div_st.done, state_reg == T_DIV)
    `EDMF_ASSERT_IMPLY(a_rank_done_phase, clk, rst_n, rank_st.done, state_reg == T_RANK)
    // the rank unit only works while the sequencer waits for it
    `EDMF_ASSERT_IMPLY(a_rank_busy_phase, clk, rst_n, rank_st.busy, state_reg == T_RANK)
    // a result only waits internally while the output register is occupied
    `EDMF_ASSERT_IMPLY(a_hold_needs_full, clk, rst_n, state_reg == T_HOLD, out_valid_reg)
    // an accepted item always starts the divider
    `EDMF_ASSERT_NEXT(a_accept_starts_div, clk, rst_n, in_accept, div_st.busy)

endmodule
`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the echo distance median filter
`timescale 1ns / 1ps
module tb;

    localparam int DIST_W = edmf_pkg::DIST_W;
    localparam int DIV_W  = edmf_pkg::DIV_W;

    // window geometry, kept in step with the block's default parameter
    localparam int WIN         = 8;
    localparam int MEDIAN_RANK = WIN / 2;

    // pause before a divisor write, a little over the time the block takes for one item
    localparam int SETTLE_CYCLES = 120;
    // quiet stretch at the end in which a stray result would show up
    localparam int DRAIN_CYCLES  = 200;
    // long receiver hold-off, far longer than one item takes
    localparam int HOLD_CYCLES   = 1500;
    // limit for the slowest legal run, roughly 1900 items plus pauses
    localparam int LIMIT_CYCLES  = 1500000;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 230;
    localparam int REPORT_MAX       = 10;

    // receiver behaviour between hold-offs
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // one expected result item
    typedef struct {
        logic [DIST_W-1:0] raw;
        logic [DIST_W-1:0] median;
    } distance_result_t;

    logic clk;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic              in_valid     = 1'b0;
    logic [DIST_W-1:0] echo_time_us = '0;
    logic              out_stall    = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic [DIV_W-1:0]  cfg_data     = '0;

    // block outputs
    logic              in_stall;
    logic              out_valid;
    logic [DIST_W-1:0] raw_cm;
    logic [DIST_W-1:0] median_cm;
    logic              cfg_ready;

    echo_distance_median_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .echo_time_us (echo_time_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .raw_cm       (raw_cm),
        .median_cm    (median_cm),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // predictor state: our own copy of the ring window and divisor
    logic [DIST_W-1:0] dist_window [WIN];
    logic [2:0]        dist_wr_pos;
    logic [DIV_W-1:0]  divisor_now;

    // echo times waiting to be offered, and results still owed by the block
    logic [DIST_W-1:0] echo_pending_q [$];
    distance_result_t  distance_expect_q [$];

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned divisor_writes = 0;
    int unsigned holdoffs_done  = 0;
    int unsigned cycle_count    = 0;

    logic [DIST_W-1:0] last_echo = '0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rank count over the window, ties fill consecutive ranks
    function automatic logic [DIST_W-1:0] window_median();
        int below;
        int not_above;
        for (int i = 0; i < WIN; i++)
        begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < WIN; j++)
            begin
                if (dist_window[j] < dist_window[i])
                    below++;
                if (dist_window[j] <= dist_window[i])
                    not_above++;
            end
            if (below <= MEDIAN_RANK && MEDIAN_RANK < not_above)
                return dist_window[i];
        end
        return '0;
    endfunction

    // convert one accepted echo, insert it and queue the result it owes
    task automatic predict_distance(input logic [DIST_W-1:0] echo);
        distance_result_t res;
        logic [DIST_W-1:0] dist_val;
        // a zero divisor saturates the divider
        if (divisor_now == '0)
            dist_val = '1;
        else
            dist_val = echo / divisor_now;
        dist_window[dist_wr_pos] = dist_val;
        // three bits wrap from the last entry back to zero
        dist_wr_pos = dist_wr_pos + 3'd1;
        res.raw    = dist_val;
        res.median = window_median();
        distance_expect_q.push_back(res);
    endtask

    // random echo time, shaped around the current divisor
    function automatic logic [DIST_W-1:0] random_echo(input logic [DIV_W-1:0] div);
        int unsigned k;
        int          v;
        logic [DIST_W-1:0] e;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: e = DIST_W'($urandom);
            4:          e = DIST_W'($urandom_range(0, 255));
            5:          e = 16'hFFFF - DIST_W'($urandom_range(0, 255));
            6:
            begin
                // right on or just below a multiple of the divisor
                if (div == '0)
                begin
                    e = DIST_W'($urandom);
                end
                else
                begin
                    k = $urandom_range(0, 65535 / div);
                    v = int'(k * div) - int'($urandom_range(0, 1));
                    if (v < 0)
                        v = 0;
                    e = v[DIST_W-1:0];
                end
            end
            7:          e = last_echo;      // repeats build ties in the window
            8:          e = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            default:
            begin
                e = 16'h0001 << $urandom_range(0, DIST_W - 1);
                if ($urandom_range(0, 1) == 0)
                    e = ~e;
            end
        endcase
        last_echo = e;
        return e;
    endfunction

    task automatic queue_echo(input logic [DIST_W-1:0] echo);
        echo_pending_q.push_back(echo);
        items_queued++;
    endtask

    // everything offered has gone in and every result has come back
    task automatic wait_idle();
        while (items_accepted != items_queued || distance_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // divisor write, only once the block has gone quiet
    task automatic write_divisor(input logic [DIV_W-1:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        divisor_now  = value;
        divisor_writes++;
    endtask

    // sender: bursts of random length separated by random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin : item_driver
        logic took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predict_distance(echo_time_us);
                items_accepted++;
            end
            // a held item stays put until taken
            if (!in_valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (echo_pending_q.size() > 0)
                begin
                    in_valid     <= 1'b1;
                    echo_time_us <= echo_pending_q.pop_front();
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // now and then a long stretch with no gaps at all
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall pattern plus two long hold-offs
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned stall_tick = 0;
    logic        hold_a_done = 1'b0;
    logic        hold_b_done = 1'b0;

    always @(posedge clk)
    begin : result_stall
        logic stall_next;
        stall_next = 1'b0;
        if (rst_n)
        begin
            stall_tick++;
            // the hold-offs start well inside the random traffic
            if (hold_left == 0 && !hold_a_done && results_seen >= 400)
            begin
                hold_left   = HOLD_CYCLES;
                hold_a_done = 1'b1;
                holdoffs_done++;
            end
            if (hold_left == 0 && !hold_b_done && results_seen >= 1300)
            begin
                hold_left   = HOLD_CYCLES;
                hold_b_done = 1'b1;
                holdoffs_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 400);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: stall_next = ((stall_tick % 5) < 2);
                    default:        stall_next = 1'b0;
                endcase
            end
        end
        out_stall <= stall_next;
    end

    // monitor: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        distance_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (distance_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result raw_cm=%0d median_cm=%0d",
                             $realtime, raw_cm, median_cm);
            end
            else
            begin
                want = distance_expect_q.pop_front();
                if (raw_cm !== want.raw || median_cm !== want.median)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result %0d raw_cm exp %0d got %0d, median_cm exp %0d got %0d",
                                 $realtime, results_seen, want.raw, raw_cm,
                                 want.median, median_cm);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results owed",
                     cycle_count, distance_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        logic [DIV_W-1:0] phase_div;
        // predictor starts from the reset state of the block
        for (int i = 0; i < WIN; i++)
            dist_window[i] = '0;
        dist_wr_pos = '0;
        divisor_now = edmf_pkg::US_PER_CM_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset divisor: window not yet full, field extremes, then ties and wrap
        queue_echo(16'd0);
        queue_echo(16'hFFFF);
        queue_echo(16'd57);
        queue_echo(16'd58);
        queue_echo(16'd116);
        repeat (5) queue_echo(16'hFFFF);
        queue_echo(16'd3364);

        // zero divisor saturates and the saturated value enters the window
        write_divisor(8'd0);
        queue_echo(16'd0);
        queue_echo(16'd12345);
        queue_echo(16'hFFFF);

        // smallest and largest divisors
        write_divisor(8'd1);
        queue_echo(16'hFFFF);
        queue_echo(16'd0);
        queue_echo(16'd1);
        queue_echo(16'h8000);

        write_divisor(8'd255);
        queue_echo(16'hFFFF);
        queue_echo(16'd254);
        queue_echo(16'd255);

        // random traffic, one divisor setting per phase
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       phase_div = edmf_pkg::US_PER_CM_RESET;
                1:       phase_div = 8'd255;
                2:       phase_div = 8'd1;
                3:       phase_div = 8'd0;
                4:       phase_div = 8'd7;
                default: phase_div = DIV_W'($urandom_range(1, 255));
            endcase
            write_divisor(phase_div);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_echo(random_echo(phase_div));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d echo items over %0d divisor writes (zero, 1, 255 and reset value among them)",
                 items_accepted, divisor_writes);
        $display("checked %0d results with %0d long receiver hold-offs, %0d failures",
                 results_seen, holdoffs_done, mismatches);
        if (mismatches == 0 && distance_expect_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
